// File: rtl/rmot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmot_pkg
// Shared types and codes of the recursive mutex owner table.
// ----------------------------------------------------------------------------
package rmot_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_COUNT_BITS    = 8;

    localparam logic [2:0] FN_LOCK      = 3'd0;
    localparam logic [2:0] FN_TRYLOCK   = 3'd1;
    localparam logic [2:0] FN_UNLOCK    = 3'd2;
    localparam logic [2:0] FN_DESTROY   = 3'd3;
    localparam logic [2:0] FN_CW_RELEASE = 3'd4;
    localparam logic [2:0] FN_CW_REACQ  = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FAILED     = 3'd1;
    localparam logic [2:0] ST_NOT_HOLDER = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_SATURATED  = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] lock_addr;
        logic [15:0] requester_id;
        logic        call_ok;
        logic        libc_lock;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        entry_present;
        logic [15:0] holder_id;
        logic [7:0]  hold_count;
    } rsp_word_t;

    // A search or insert request travelling down the row of cells.
    typedef struct packed {
        logic      vld;
        logic      insert;
        logic      done;
        req_word_t req;
        rsp_word_t rsp;
    } token_t;

endpackage

// File: rtl/recursive_mutex_owner_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_mutex_owner_table_top
// Owner table of recursive mutexes, built as a row of slot cells.
//
//   Channel  Signals                        Payload
//   req      req_valid / req_ready          req_word (func, address, id, flags)
//   rsp      rsp_valid / rsp_ready          rsp_word (status, entry view)
//
// A word walks the row of TABLE_ENTRIES cells, one cell per cycle; a word that
// must insert a new entry walks the row a second time.
// Reset empties every slot at once; no clearing pass follows.
// A new word is taken once the previous result has moved to the output
// register, even while that response still waits there.
// ----------------------------------------------------------------------------
module recursive_mutex_owner_table_top
    import rmot_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_INSERT = 4'b0100,
        S_HOLD   = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    rsp_word_t res_reg, res_next;
    rsp_word_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    token_t    chain [TABLE_ENTRIES+1];
    token_t    head;
    token_t    tail;

    assign tail = chain[TABLE_ENTRIES];

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        head           = '0;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    head.vld   = 1'b1;
                    head.req   = req_word;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tail.vld)
                begin
                    res_next   = '0;
                    state_next = S_HOLD;
                    priority if (tail.done)
                    begin
                        res_next = tail.rsp;
                    end
                    else if (tail.req.func <= FN_DESTROY && !tail.req.call_ok)
                    begin
                        res_next.status = ST_FAILED;
                    end
                    else if (tail.req.func == FN_LOCK || tail.req.func == FN_TRYLOCK
                             || tail.req.func == FN_CW_REACQ)
                    begin
                        head        = tail;
                        head.insert = 1'b1;
                        state_next  = S_INSERT;
                    end
                    else if (tail.req.func == FN_UNLOCK || tail.req.func == FN_DESTROY
                             || tail.req.func == FN_CW_RELEASE)
                    begin
                        res_next.status = ST_UNKNOWN;
                    end
                    else
                    begin
                        res_next.status = ST_FAILED;
                    end
                end
            end
            S_INSERT:
            begin
                if (tail.vld)
                begin
                    state_next = S_HOLD;
                    if (tail.done)
                    begin
                        res_next = tail.rsp;
                    end
                    else
                    begin
                        res_next        = '0;
                        res_next.status = ST_FULL;
                    end
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign chain[0] = head;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        rmot_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

endmodule

// File: rtl/rmot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmot_cell
// One table slot; applies a passing token to its entry and hands it on.
// ----------------------------------------------------------------------------
module rmot_cell
    import rmot_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic                  valid_reg, valid_next;
    logic [31:0]           addr_reg, addr_next;
    logic [15:0]           holder_reg, holder_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  libc_reg, libc_next;
    token_t                tok_reg, tok_next;

    logic                  hit;
    logic                  fill;
    logic                  is_holder;
    logic [COUNT_BITS+7:0] cnt_wide;

    assign hit = tok_in.vld && !tok_in.insert && !tok_in.done && valid_reg
                 && (addr_reg == tok_in.req.lock_addr);
    assign fill = tok_in.vld && tok_in.insert && !tok_in.done && !valid_reg;
    assign is_holder = (holder_reg == tok_in.req.requester_id);
    assign cnt_wide = (COUNT_BITS + 8)'(count_next);

    always_comb
    begin
        valid_next  = valid_reg;
        addr_next   = addr_reg;
        holder_next = holder_reg;
        count_next  = count_reg;
        libc_next   = libc_reg;
        tok_next    = tok_in;
        if (hit)
        begin
            tok_next.done       = 1'b1;
            tok_next.rsp.status = ST_OK;
            priority if (tok_in.req.func <= FN_DESTROY && !tok_in.req.call_ok)
            begin
                tok_next.rsp.status = ST_FAILED;
            end
            else if (tok_in.req.func == FN_LOCK || tok_in.req.func == FN_TRYLOCK)
            begin
                if (is_holder)
                begin
                    if (count_reg == CNT_MAX)
                        tok_next.rsp.status = ST_SATURATED;
                    else
                        count_next = count_reg + CNT_ONE;
                end
                else
                begin
                    holder_next = tok_in.req.requester_id;
                    count_next  = CNT_ONE;
                end
            end
            else if (tok_in.req.func == FN_UNLOCK)
            begin
                if (is_holder && count_reg != '0)
                begin
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                        holder_next = '0;
                end
                else
                begin
                    tok_next.rsp.status = ST_NOT_HOLDER;
                end
            end
            else if (tok_in.req.func == FN_DESTROY)
            begin
                valid_next = 1'b0;
            end
            else if (tok_in.req.func == FN_CW_RELEASE)
            begin
                if (is_holder)
                begin
                    holder_next = '0;
                    count_next  = '0;
                end
                else
                begin
                    tok_next.rsp.status = ST_NOT_HOLDER;
                end
            end
            else if (tok_in.req.func == FN_CW_REACQ)
            begin
                holder_next = tok_in.req.requester_id;
                count_next  = CNT_ONE;
            end
            else
            begin
                tok_next.rsp.status = ST_FAILED;
            end
        end
        else if (fill)
        begin
            valid_next          = 1'b1;
            addr_next           = tok_in.req.lock_addr;
            holder_next         = tok_in.req.requester_id;
            count_next          = CNT_ONE;
            libc_next           = tok_in.req.libc_lock;
            tok_next.done       = 1'b1;
            tok_next.rsp.status = ST_OK;
        end

        if (hit || fill)
        begin
            tok_next.rsp.entry_present = valid_next;
            tok_next.rsp.holder_id     = valid_next ? holder_next : 16'd0;
            tok_next.rsp.hold_count    = valid_next ? cnt_wide[7:0] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        holder_reg <= holder_next;
        count_reg  <= count_next;
        libc_reg   <= libc_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recursive mutex owner table.
//
// A short scripted run covers the edge cases first: unknown locks, failed
// calls, recursion, takeover, count saturation, a full table and the spare
// function codes. A long random run of lock events follows. It mostly uses a
// small pool of addresses and thread ids, so that entries are locked,
// unlocked, released and destroyed over and over. Every accepted word goes
// through a behavioral copy of the table, and each response word is compared
// field by field with the oldest queued view (scripted or predicted). Both
// sides of the block idle at random. The response side once holds off long
// enough for the request side to back up, and the request side waits for the
// block to drain after the scripted run and once in the random run.
// ----------------------------------------------------------------------------
module tb_top;
    import rmot_pkg::*;

    localparam logic [2:0] FN_RESERVED_A  = 3'd6;
    localparam logic [2:0] FN_RESERVED_B  = 3'd7;
    localparam int         SLOTS          = DEF_TABLE_ENTRIES;
    localparam logic [7:0] COUNT_MAX      = 8'((1 << DEF_COUNT_BITS) - 1);
    localparam int         RANDOM_WORDS   = 110;
    localparam int         ADDR_POOL      = 20;
    localparam int         ID_POOL        = 4;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 2 * SLOTS + 8;
    localparam int         REPORT_LIMIT   = 10;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_STALLED} rx_mode_t;

    typedef struct packed {
        req_word_t  word;
        logic [8:0] reps;
        logic [7:0] stride;
        logic       fixed;
        rsp_word_t  want;
    } script_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp_word;

    logic        tbl_valid  [SLOTS];
    logic [31:0] tbl_addr   [SLOTS];
    logic [15:0] tbl_holder [SLOTS];
    logic [7:0]  tbl_count  [SLOTS];
    logic        tbl_libc   [SLOTS];

    script_row_t lock_script [$];
    rsp_word_t   owner_view_q [$];
    rsp_word_t   want_w;
    int          mismatches = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    bit          hold_rsp = 1'b0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int          rx_tick = 0;

    recursive_mutex_owner_table_top #(
        .TABLE_ENTRIES(SLOTS),
        .COUNT_BITS   (DEF_COUNT_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word (rsp_word)
    );

    always #10 clk = ~clk;

    function automatic int lookup_slot(logic [31:0] addr);
        int hit;
        hit = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_addr[i] == addr)
                hit = i;
        return hit;
    endfunction

    function automatic int claim_slot(req_word_t w);
        int free_i;
        free_i = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_valid[i])
                free_i = i;
        if (free_i >= 0)
        begin
            tbl_valid[free_i]  = 1'b1;
            tbl_addr[free_i]   = w.lock_addr;
            tbl_holder[free_i] = w.requester_id;
            tbl_count[free_i]  = 8'd1;
            tbl_libc[free_i]   = w.libc_lock;
        end
        return free_i;
    endfunction

    function automatic rsp_word_t apply_lock_event(req_word_t w);
        int        s;
        rsp_word_t r;
        s = lookup_slot(w.lock_addr);
        r = '0;
        r.status = ST_OK;
        if (w.func <= FN_DESTROY && !w.call_ok)
            r.status = ST_FAILED;
        else
        begin
            case (w.func)
                FN_LOCK, FN_TRYLOCK:
                begin
                    if (s < 0)
                    begin
                        s = claim_slot(w);
                        if (s < 0)
                            r.status = ST_FULL;
                    end
                    else if (tbl_holder[s] == w.requester_id)
                    begin
                        if (tbl_count[s] == COUNT_MAX)
                            r.status = ST_SATURATED;
                        else
                            tbl_count[s] = tbl_count[s] + 8'd1;
                    end
                    else
                    begin
                        tbl_holder[s] = w.requester_id;
                        tbl_count[s]  = 8'd1;
                    end
                end
                FN_UNLOCK:
                begin
                    if (s < 0)
                        r.status = ST_UNKNOWN;
                    else if (tbl_holder[s] == w.requester_id && tbl_count[s] != 8'd0)
                    begin
                        tbl_count[s] = tbl_count[s] - 8'd1;
                        if (tbl_count[s] == 8'd0)
                            tbl_holder[s] = 16'd0;
                    end
                    else
                        r.status = ST_NOT_HOLDER;
                end
                FN_DESTROY:
                begin
                    if (s < 0)
                        r.status = ST_UNKNOWN;
                    else
                    begin
                        tbl_valid[s] = 1'b0;
                        s = -1;
                    end
                end
                FN_CW_RELEASE:
                begin
                    if (s < 0)
                        r.status = ST_UNKNOWN;
                    else if (tbl_holder[s] == w.requester_id)
                    begin
                        tbl_holder[s] = 16'd0;
                        tbl_count[s]  = 8'd0;
                    end
                    else
                        r.status = ST_NOT_HOLDER;
                end
                FN_CW_REACQ:
                begin
                    if (s < 0)
                    begin
                        s = claim_slot(w);
                        if (s < 0)
                            r.status = ST_FULL;
                    end
                    else
                    begin
                        tbl_holder[s] = w.requester_id;
                        tbl_count[s]  = 8'd1;
                    end
                end
                default:
                    r.status = ST_FAILED;
            endcase
        end
        if (s >= 0)
        begin
            r.entry_present = 1'b1;
            r.holder_id     = tbl_holder[s];
            r.hold_count    = tbl_count[s];
        end
        return r;
    endfunction

    task automatic add_row(logic [2:0] f, logic [31:0] a, logic [15:0] id, logic ok,
                           logic lc, int reps, int stride, logic chk,
                           logic [2:0] st, logic pr, logic [15:0] h, logic [7:0] c);
        script_row_t row;
        row.word   = '{func: f, lock_addr: a, requester_id: id, call_ok: ok, libc_lock: lc};
        row.reps   = 9'(reps);
        row.stride = 8'(stride);
        row.fixed  = chk;
        row.want   = '{status: st, entry_present: pr, holder_id: h, hold_count: c};
        lock_script.push_back(row);
    endtask

    task automatic offer(req_word_t w, logic use_want, rsp_word_t want);
        rsp_word_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (!req_ready);
        predicted = apply_lock_event(w);
        owner_view_q.push_back(use_want ? want : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (owner_view_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string what, rsp_word_t want, rsp_word_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%0t %s: expected status %0d present %0d holder %h count %0d,",
                      " got status %0d present %0d holder %h count %0d"},
                     $realtime, what, want.status, want.entry_present, want.holder_id,
                     want.hold_count, got.status, got.entry_present, got.holder_id,
                     got.hold_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owner_view_q.size() == 0)
                report_mismatch("word with nothing outstanding", '0, rsp_word);
            else
            begin
                want_w = owner_view_q.pop_front();
                if (rsp_word.status !== want_w.status
                    || rsp_word.entry_present !== want_w.entry_present
                    || rsp_word.holder_id !== want_w.holder_id
                    || rsp_word.hold_count !== want_w.hold_count)
                    report_mismatch("entry view differs", want_w, rsp_word);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("recursive_mutex_owner_table_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_left = $urandom_range(1, 60);
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:         rsp_ready <= 1'b1;
                    RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: rsp_ready <= (rx_tick % 4 == 0);
                    default:         rsp_ready <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin
        req_word_t   w;
        logic [31:0] addr_pool [ADDR_POOL];
        logic [15:0] id_pool [ID_POOL];
        int          pick;
        int          s;

        req_valid = 1'b0;
        req_word  = '0;
        rst_n     = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(FN_UNLOCK, 32'h0, 16'h0001, 1, 0, 1, 0, 1, ST_UNKNOWN, 0, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'h0, 16'h0001, 0, 0, 1, 0, 1, ST_FAILED, 0, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'h0, 16'hFFFF, 1, 1, 1, 0, 1, ST_OK, 1, 16'hFFFF, 8'd1);
        add_row(FN_TRYLOCK, 32'h0, 16'hFFFF, 1, 0, 1, 0, 1, ST_OK, 1, 16'hFFFF, 8'd2);
        add_row(FN_LOCK, 32'h0, 16'h0001, 1, 0, 1, 0, 1, ST_OK, 1, 16'h0001, 8'd1);
        add_row(FN_UNLOCK, 32'h0, 16'hFFFF, 1, 0, 1, 0, 1, ST_NOT_HOLDER, 1, 16'h0001, 8'd1);
        add_row(FN_UNLOCK, 32'h0, 16'h0001, 1, 0, 1, 0, 1, ST_OK, 1, 16'h0, 8'd0);
        add_row(FN_UNLOCK, 32'h0, 16'h0001, 1, 0, 1, 0, 1, ST_NOT_HOLDER, 1, 16'h0, 8'd0);
        add_row(FN_CW_RELEASE, 32'hFFFF_FFFF, 16'h0001, 1, 1, 1, 0, 1,
                ST_UNKNOWN, 0, 16'h0, 8'd0);
        add_row(FN_CW_REACQ, 32'hFFFF_FFFF, 16'h8000, 0, 0, 1, 0, 1,
                ST_OK, 1, 16'h8000, 8'd1);
        add_row(FN_CW_RELEASE, 32'hFFFF_FFFF, 16'h0001, 1, 0, 1, 0, 1,
                ST_NOT_HOLDER, 1, 16'h8000, 8'd1);
        add_row(FN_CW_RELEASE, 32'hFFFF_FFFF, 16'h8000, 0, 1, 1, 0, 1,
                ST_OK, 1, 16'h0, 8'd0);
        add_row(FN_CW_REACQ, 32'hFFFF_FFFF, 16'h0002, 1, 1, 1, 0, 1,
                ST_OK, 1, 16'h0002, 8'd1);
        add_row(FN_RESERVED_A, 32'hFFFF_FFFF, 16'h0003, 0, 0, 1, 0, 1,
                ST_FAILED, 1, 16'h0002, 8'd1);
        add_row(FN_RESERVED_B, 32'h1234_5678, 16'h0003, 1, 1, 1, 0, 1,
                ST_FAILED, 0, 16'h0, 8'd0);
        add_row(FN_DESTROY, 32'hFFFF_FFFF, 16'h0002, 0, 0, 1, 0, 1,
                ST_FAILED, 1, 16'h0002, 8'd1);
        add_row(FN_DESTROY, 32'hFFFF_FFFF, 16'h0002, 1, 0, 1, 0, 1, ST_OK, 0, 16'h0, 8'd0);
        add_row(FN_DESTROY, 32'hFFFF_FFFF, 16'h0002, 1, 0, 1, 0, 1,
                ST_UNKNOWN, 0, 16'h0, 8'd0);
        add_row(FN_UNLOCK, 32'h0, 16'h0001, 0, 0, 1, 0, 1, ST_FAILED, 1, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'h5555_AAAA, 16'h1234, 1, 1, COUNT_MAX, 0, 0,
                ST_OK, 0, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'h5555_AAAA, 16'h1234, 1, 0, 1, 0, 1,
                ST_SATURATED, 1, 16'h1234, COUNT_MAX);
        add_row(FN_UNLOCK, 32'h5555_AAAA, 16'h1234, 1, 0, 1, 0, 1,
                ST_OK, 1, 16'h1234, COUNT_MAX - 8'd1);
        add_row(FN_LOCK, 32'h0000_0100, 16'h0007, 1, 0, SLOTS - 2, 1, 0,
                ST_OK, 0, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'hDEAD_0000, 16'h0009, 1, 1, 1, 0, 1, ST_FULL, 0, 16'h0, 8'd0);
        add_row(FN_CW_REACQ, 32'hDEAD_0000, 16'h0009, 1, 0, 1, 0, 1,
                ST_FULL, 0, 16'h0, 8'd0);
        add_row(FN_TRYLOCK, 32'hDEAD_0000, 16'h0009, 0, 0, 1, 0, 1,
                ST_FAILED, 0, 16'h0, 8'd0);
        add_row(FN_DESTROY, 32'h0, 16'h0009, 1, 0, 1, 0, 1, ST_OK, 0, 16'h0, 8'd0);
        add_row(FN_LOCK, 32'hDEAD_0000, 16'h0009, 1, 1, 1, 0, 1, ST_OK, 1, 16'h0009, 8'd1);

        foreach (lock_script[i])
            for (int k = 0; k < lock_script[i].reps; k++)
            begin
                w = lock_script[i].word;
                w.lock_addr = w.lock_addr + k * lock_script[i].stride;
                offer(w, lock_script[i].fixed, lock_script[i].want);
            end
        drain();

        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < ADDR_POOL; i++)
            addr_pool[i] = $urandom();
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = 16'($urandom_range(1, 65535));

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 30)
                hold_rsp = 1'b1;
            if (n == 70)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 28)
                w.func = FN_LOCK;
            else if (pick < 38)
                w.func = FN_TRYLOCK;
            else if (pick < 64)
                w.func = FN_UNLOCK;
            else if (pick < 74)
                w.func = FN_DESTROY;
            else if (pick < 84)
                w.func = FN_CW_RELEASE;
            else if (pick < 94)
                w.func = FN_CW_REACQ;
            else if (pick < 97)
                w.func = FN_RESERVED_A;
            else
                w.func = FN_RESERVED_B;

            pick = $urandom_range(0, 99);
            s = $urandom_range(0, SLOTS - 1);
            if (w.func == FN_DESTROY && pick < 50 && tbl_valid[s])
                w.lock_addr = tbl_addr[s];
            else if (pick < 4)
                w.lock_addr = $urandom();
            else
                w.lock_addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];

            s = lookup_slot(w.lock_addr);
            pick = $urandom_range(0, 99);
            if (s >= 0 && tbl_holder[s] != 16'd0 && pick < 60)
                w.requester_id = tbl_holder[s];
            else if (pick < 90)
                w.requester_id = id_pool[$urandom_range(0, ID_POOL - 1)];
            else
                w.requester_id = 16'($urandom_range(1, 65535));

            w.call_ok   = ($urandom_range(0, 99) < 92);
            w.libc_lock = 1'($urandom_range(0, 1));
            offer(w, 1'b0, '0);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (owner_view_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("recursive_mutex_owner_table_top: match");
        else
            $display("recursive_mutex_owner_table_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/rmot_pkg.sv
rtl/rmot_cell.sv
rtl/recursive_mutex_owner_table_top.sv
bench/tb_top.sv
